FILE: rtl/ebrd_pkg.sv
// ----------------------------------------------------------------------------
// ebrd_pkg
// Shared widths, constants, register indexes and the divider request type
// for the ECG beat rate detector.
// ----------------------------------------------------------------------------
package ebrd_pkg;

  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned TIME_BITS   = 32;
  localparam int unsigned LEVEL_BITS  = 5;
  localparam int unsigned RATE_BITS   = 12;
  localparam int unsigned SUM_BITS    = 16;
  localparam int unsigned COUNT_BITS  = 4;
  localparam int unsigned WIN_BITS    = 16;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned CFG_IDX_BITS  = 3;

  // Dividend width of the shared divider: covers the rate scale, the rate sum
  // and the sample.
  localparam int unsigned DIV_BITS     = 20;
  localparam int unsigned DIV_CNT_BITS = $clog2(DIV_BITS);

  localparam logic [DIV_BITS-1:0]   RATE_SCALE = DIV_BITS'(960000);
  localparam logic [RATE_BITS-1:0]  RATE_MAX   = RATE_BITS'(4095);
  localparam logic [LEVEL_BITS-1:0] LEVEL_MIN  = LEVEL_BITS'(1);
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX  = LEVEL_BITS'(16);

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_SAMPLES    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_DIVISOR     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_OFFSET      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BEAT_LEVEL        = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_REFRACTORY_MS     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_BEATS_PER_AVERAGE = 3'd5;

  typedef struct packed {
    logic                 start;
    logic [DIV_BITS-1:0]  dividend;
    logic [TIME_BITS-1:0] divisor;
  } ebrd_div_req_t;

endpackage

FILE: rtl/ebrd_div.sv
// ----------------------------------------------------------------------------
// ebrd_div
// Restoring radix-2 divider, one quotient bit per cycle. Quotient is valid in
// the cycle that done_o is high.
// ----------------------------------------------------------------------------
module ebrd_div
  import ebrd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ebrd_div_req_t       req_i,
  output logic                done_o,
  output logic [DIV_BITS-1:0] quotient_o
);

  logic [DIV_BITS-1:0]     rem_q, rem_d;
  logic [DIV_BITS-1:0]     quo_q, quo_d;
  logic [TIME_BITS-1:0]    dvs_q;
  logic [DIV_CNT_BITS-1:0] cnt_q;
  logic                    busy_q;
  logic                    done_q;

  logic [DIV_BITS:0]    shifted;
  logic [TIME_BITS-1:0] shifted_ext;
  logic                 fits;
  logic [TIME_BITS-1:0] diff;

  // Partial remainder never exceeds the dividend, so it stays in DIV_BITS.
  always_comb begin
    shifted     = {rem_q, quo_q[DIV_BITS-1]};
    shifted_ext = TIME_BITS'(shifted);
    fits        = (shifted_ext >= dvs_q);
    diff        = shifted_ext - dvs_q;
    rem_d       = fits ? diff[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];
    quo_d       = {quo_q[DIV_BITS-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_BITS'(DIV_BITS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_no_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider restarted while busy");

  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held for more than one cycle");

endmodule

FILE: rtl/ecg_beat_rate_detector.sv
// ----------------------------------------------------------------------------
// ecg_beat_rate_detector
// Window peak tracker, display level mapper and beat rate averager. One
// shared serial divider forms the level, the beat rate and the average.
//
//   channel   direction  handshake               payload
//   in        sink       in_valid_i/in_ready_o   sample_i, time_ms_i
//   out       source     out_valid_o/out_ready_i level_o, beat_o,
//                                                average_valid_o,
//                                                average_bpm_o, window_done_o
//   cfg       sink       cfg_we_i                cfg_index_i, cfg_data_i
//
// A word passes through an accept step, the level division, the rate division
// when it is a beat, the average division when an average is formed, and the
// output step, in that order; each division hands its quotient on when done.
// in_ready_o is high only while the sequencer is idle; the next word may be
// accepted while the previous result waits in the output register.
// The result stage stalls while the output register is full and not taken.
// Reset loads the register defaults and clears all tracking state.
// ----------------------------------------------------------------------------
module ecg_beat_rate_detector
  import ebrd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  input  logic [TIME_BITS-1:0]     time_ms_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [LEVEL_BITS-1:0]    level_o,
  output logic                     beat_o,
  output logic                     average_valid_o,
  output logic [RATE_BITS-1:0]     average_bpm_o,
  output logic                     window_done_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LVL  = 3'd1;
  localparam logic [2:0] S_RATE = 3'd2;
  localparam logic [2:0] S_AVG  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;

  // configuration
  logic [WIN_BITS-1:0]   win_samples_q;
  logic [7:0]            lvl_div_q;
  logic [7:0]            lvl_off_q;
  logic [LEVEL_BITS-1:0] beat_lvl_q;
  logic [15:0]           refr_q;
  logic [COUNT_BITS-1:0] bpa_q;

  // tracking state
  logic [SAMPLE_BITS-1:0] win_max_q;
  logic [TIME_BITS-1:0]   last_beat_q;
  logic [SUM_BITS-1:0]    rate_sum_q;
  logic [COUNT_BITS-1:0]  beat_cnt_q;
  logic [WIN_BITS-1:0]    win_cnt_q;

  // per-word work registers
  logic [TIME_BITS-1:0]  time_q;
  logic [LEVEL_BITS-1:0] level_q;
  logic                  beat_q;
  logic                  avg_valid_q;
  logic [RATE_BITS-1:0]  avg_q;

  // output register
  logic                  out_valid_q;
  logic [LEVEL_BITS-1:0] out_level_q;
  logic                  out_beat_q;
  logic                  out_avg_valid_q;
  logic [RATE_BITS-1:0]  out_avg_q;
  logic                  out_done_q;

  ebrd_div_req_t       div_req;
  logic                div_done;
  logic [DIV_BITS-1:0] div_quo;

  logic                   in_fire;
  logic [SAMPLE_BITS-1:0] new_max;
  logic [7:0]             div_eff;
  logic [COUNT_BITS-1:0]  nbeats;
  logic [DIV_BITS-1:0]    lvl_diff;
  logic [LEVEL_BITS-1:0]  level_calc;
  logic [TIME_BITS-1:0]   elapsed;
  logic                   beat_ok;
  logic [RATE_BITS-1:0]   div_sat;
  logic [SUM_BITS-1:0]    sum_new;
  logic [COUNT_BITS-1:0]  cnt_new;
  logic                   avg_due;
  logic [WIN_BITS:0]      win_next;
  logic                   win_end;
  logic                   out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    new_max  = (sample_i > win_max_q) ? sample_i : win_max_q;
    div_eff  = (lvl_div_q == '0) ? 8'd1 : lvl_div_q;
    nbeats   = (bpa_q == '0) ? COUNT_BITS'(1) : bpa_q;

    lvl_diff = div_quo - DIV_BITS'(lvl_off_q);
    if (div_quo <= DIV_BITS'(lvl_off_q)) begin
      level_calc = LEVEL_MIN;
    end else if (lvl_diff > DIV_BITS'(LEVEL_MAX)) begin
      level_calc = LEVEL_MAX;
    end else begin
      level_calc = lvl_diff[LEVEL_BITS-1:0];
    end

    elapsed = time_q - last_beat_q;
    beat_ok = (level_calc > beat_lvl_q) && (elapsed > TIME_BITS'(refr_q));

    div_sat = (div_quo > DIV_BITS'(RATE_MAX)) ? RATE_MAX : div_quo[RATE_BITS-1:0];
    sum_new = rate_sum_q + SUM_BITS'(div_sat);
    cnt_new = beat_cnt_q + 1'b1;
    avg_due = (cnt_new >= nbeats);

    win_next = {1'b0, win_cnt_q} + 1'b1;
    win_end  = (win_next >= {1'b0, win_samples_q});
  end

  // divider request mux
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state_q)
      S_IDLE: begin
        div_req.start    = in_fire;
        div_req.dividend = DIV_BITS'(new_max);
        div_req.divisor  = TIME_BITS'(div_eff);
      end
      S_LVL: begin
        div_req.start    = div_done && beat_ok;
        div_req.dividend = RATE_SCALE;
        div_req.divisor  = elapsed;
      end
      S_RATE: begin
        div_req.start    = div_done && avg_due;
        div_req.dividend = DIV_BITS'(sum_new);
        div_req.divisor  = TIME_BITS'(nbeats);
      end
      S_AVG, S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_fire) state_d = S_LVL;
      S_LVL: begin
        if (div_done) state_d = beat_ok ? S_RATE : S_OUT;
      end
      S_RATE: begin
        if (div_done) state_d = avg_due ? S_AVG : S_OUT;
      end
      S_AVG: if (div_done) state_d = S_OUT;
      S_OUT: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  ebrd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_samples_q <= WIN_BITS'(30000);
      lvl_div_q     <= 8'd30;
      lvl_off_q     <= 8'd87;
      beat_lvl_q    <= LEVEL_BITS'(11);
      refr_q        <= 16'd300;
      bpa_q         <= COUNT_BITS'(5);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WINDOW_SAMPLES:    win_samples_q <= cfg_data_i;
        REG_LEVEL_DIVISOR:     lvl_div_q     <= cfg_data_i[7:0];
        REG_LEVEL_OFFSET:      lvl_off_q     <= cfg_data_i[7:0];
        REG_BEAT_LEVEL:        beat_lvl_q    <= cfg_data_i[LEVEL_BITS-1:0];
        REG_REFRACTORY_MS:     refr_q        <= cfg_data_i;
        REG_BEATS_PER_AVERAGE: bpa_q         <= cfg_data_i[COUNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer and tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      win_max_q   <= '0;
      last_beat_q <= '0;
      rate_sum_q  <= '0;
      beat_cnt_q  <= '0;
      win_cnt_q   <= '0;
      beat_q      <= 1'b0;
      avg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            win_max_q   <= new_max;
            beat_q      <= 1'b0;
            avg_valid_q <= 1'b0;
          end
        end
        S_LVL: begin
        end
        S_RATE: begin
          if (div_done) begin
            beat_q      <= 1'b1;
            last_beat_q <= time_q;
            if (avg_due) begin
              rate_sum_q <= '0;
              beat_cnt_q <= '0;
            end else begin
              rate_sum_q <= sum_new;
              beat_cnt_q <= cnt_new;
            end
          end
        end
        S_AVG: begin
          if (div_done) avg_valid_q <= 1'b1;
        end
        S_OUT: begin
          if (out_free) begin
            if (win_end) begin
              win_cnt_q <= '0;
              win_max_q <= '0;
            end else begin
              win_cnt_q <= win_next[WIN_BITS-1:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      time_q <= time_ms_i;
      avg_q  <= '0;
    end
    if (state_q == S_LVL && div_done) level_q <= level_calc;
    if (state_q == S_AVG && div_done) avg_q <= div_sat;
    if (state_q == S_OUT && out_free) begin
      out_level_q     <= level_q;
      out_beat_q      <= beat_q;
      out_avg_valid_q <= avg_valid_q;
      out_avg_q       <= avg_q;
      out_done_q      <= win_end;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign level_o         = out_level_q;
  assign beat_o          = out_beat_q;
  assign average_valid_o = out_avg_valid_q;
  assign average_bpm_o   = out_avg_q;
  assign window_done_o   = out_done_q;

  a_avg_needs_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && average_valid_o) |-> beat_o)
    else $error("average emitted without a beat");

  a_avg_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !average_valid_o) |-> (average_bpm_o == '0))
    else $error("average value without average flag");

  a_level_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (level_o >= LEVEL_MIN && level_o <= LEVEL_MAX))
    else $error("level out of range");

  a_div_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_LVL || state_q == S_RATE || state_q == S_AVG))
    else $error("divider finished outside a waiting state");

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ECG beat rate detector. A scoreboard class
// tracks the window peak, the beat period and the rate average for every
// accepted word and checks each result word field by field. A directed run
// covers the field extremes, the time wrap and the degenerate register
// settings; random phases then retune all registers and replay sample
// streams with random gaps on both channels in all but one phase.
// ----------------------------------------------------------------------------
module tb;
  import ebrd_pkg::*;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic                  beat;
    logic                  average_valid;
    logic [RATE_BITS-1:0]  average_bpm;
    logic                  window_done;
  } report_t;

  typedef struct packed {
    logic [WIN_BITS-1:0]   window_samples;
    logic [7:0]            level_divisor;
    logic [7:0]            level_offset;
    logic [4:0]            beat_level;
    logic [15:0]           refractory_ms;
    logic [COUNT_BITS-1:0] beats_per_average;
  } settings_t;

  class beat_rate_tracker;
    settings_t             cfg;
    logic [SAMPLE_BITS-1:0] peak;
    logic [TIME_BITS-1:0]  last_beat_ms;
    logic [SUM_BITS-1:0]   rate_sum;
    logic [COUNT_BITS-1:0] beat_count;
    logic [WIN_BITS-1:0]   window_count;
    report_t               pending[$];
    int                    errors;

    function new();
      cfg = '{16'd30000, 8'd30, 8'd87, 5'd11, 16'd300, 4'd5};
      peak         = '0;
      last_beat_ms = '0;
      rate_sum     = '0;
      beat_count   = '0;
      window_count = '0;
      errors       = 0;
    endfunction

    function void note_sample(logic [SAMPLE_BITS-1:0] sample, logic [TIME_BITS-1:0] stamp);
      report_t     r;
      logic [31:0] quot;
      logic [31:0] div;
      logic [31:0] nbeats;
      logic [31:0] rate;
      logic [31:0] elapsed;
      r = '0;
      if (sample > peak) peak = sample;
      div  = (cfg.level_divisor == 0) ? 32'd1 : 32'(cfg.level_divisor);
      quot = 32'(peak) / div;
      if (quot <= 32'(cfg.level_offset)) begin
        r.level = LEVEL_MIN;
      end else if (quot - 32'(cfg.level_offset) > 32'(LEVEL_MAX)) begin
        r.level = LEVEL_MAX;
      end else begin
        r.level = LEVEL_BITS'(quot - 32'(cfg.level_offset));
      end
      // period is taken modulo 2^32, so a wrapped clock still counts
      elapsed = stamp - last_beat_ms;
      if (r.level > cfg.beat_level && elapsed > 32'(cfg.refractory_ms)) begin
        rate = 32'(RATE_SCALE) / elapsed;
        if (rate > 32'(RATE_MAX)) rate = 32'(RATE_MAX);
        r.beat     = 1'b1;
        rate_sum   = rate_sum + SUM_BITS'(rate);
        beat_count = beat_count + 1'b1;
        nbeats = (cfg.beats_per_average == 0) ? 32'd1 : 32'(cfg.beats_per_average);
        if (32'(beat_count) >= nbeats) begin
          rate = 32'(rate_sum) / nbeats;
          if (rate > 32'(RATE_MAX)) rate = 32'(RATE_MAX);
          r.average_valid = 1'b1;
          r.average_bpm   = RATE_BITS'(rate);
          rate_sum        = '0;
          beat_count      = '0;
        end
        last_beat_ms = stamp;
      end
      if (32'(window_count) + 32'd1 >= 32'(cfg.window_samples)) begin
        r.window_done = 1'b1;
        window_count  = '0;
        peak          = '0;
      end else begin
        window_count = window_count + 1'b1;
      end
      pending.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected word expected none, got level %0d beat %0d avg %0d/%0d done %0d",
                 $time, got.level, got.beat, got.average_valid, got.average_bpm,
                 got.window_done);
        return;
      end
      want = pending.pop_front();
      compare_field("level", 32'(want.level), 32'(got.level));
      compare_field("beat", 32'(want.beat), 32'(got.beat));
      compare_field("average_valid", 32'(want.average_valid), 32'(got.average_valid));
      compare_field("average_bpm", 32'(want.average_bpm), 32'(got.average_bpm));
      compare_field("window_done", 32'(want.window_done), 32'(got.window_done));
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [SAMPLE_BITS-1:0]   sample_i = '0;
  logic [TIME_BITS-1:0]     time_ms_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [LEVEL_BITS-1:0]    level_o;
  logic                     beat_o;
  logic                     average_valid_o;
  logic [RATE_BITS-1:0]     average_bpm_o;
  logic                     window_done_o;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;

  bit               steady = 1'b0;
  beat_rate_tracker tracker;

  ecg_beat_rate_detector i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .sample_i,
    .time_ms_i,
    .out_valid_o,
    .out_ready_i,
    .level_o,
    .beat_o,
    .average_valid_o,
    .average_bpm_o,
    .window_done_o,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_report({level_o, beat_o, average_valid_o, average_bpm_o, window_done_o});
    out_ready_i <= steady || ($urandom_range(99) >= 36);
  end

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic [TIME_BITS-1:0] t);
    if (!steady && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 36);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    time_ms_i  <= t;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_sample(s, t);
  endtask

  // hold the input side until every result word is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // leaves the write enable high so back-to-back writes never glitch it
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input settings_t cfg);
    write_reg(REG_WINDOW_SAMPLES, CFG_DATA_BITS'(cfg.window_samples));
    write_reg(REG_LEVEL_DIVISOR, CFG_DATA_BITS'(cfg.level_divisor));
    write_reg(REG_LEVEL_OFFSET, CFG_DATA_BITS'(cfg.level_offset));
    write_reg(REG_BEAT_LEVEL, CFG_DATA_BITS'(cfg.beat_level));
    write_reg(REG_REFRACTORY_MS, CFG_DATA_BITS'(cfg.refractory_ms));
    write_reg(REG_BEATS_PER_AVERAGE, CFG_DATA_BITS'(cfg.beats_per_average));
    cfg_we_i   <= 1'b0;
    tracker.cfg = cfg;
  endtask

  function automatic settings_t random_settings();
    settings_t   c;
    int unsigned top;
    case ($urandom_range(9))
      0: c.window_samples = '0;
      1: c.window_samples = '1;
      2: c.window_samples = 16'd1;
      default: c.window_samples = 16'($urandom_range(2, 48));
    endcase
    case ($urandom_range(9))
      0: c.level_divisor = '0;
      1: c.level_divisor = '1;
      2, 3, 4, 5: c.level_divisor = 8'($urandom_range(8, 64));
      default: c.level_divisor = 8'($urandom_range(1, 255));
    endcase
    // keep the offset at or below the top quotient most of the time so levels move
    top = 4095 / ((c.level_divisor == 0) ? 1 : c.level_divisor);
    if (top > 255 || $urandom_range(9) == 0) top = 255;
    c.level_offset = 8'($urandom_range(0, top));
    case ($urandom_range(9))
      0: c.beat_level = '0;
      1: c.beat_level = 5'($urandom_range(17, 31));
      2: c.beat_level = 5'd16;
      default: c.beat_level = 5'($urandom_range(1, 15));
    endcase
    case ($urandom_range(9))
      0: c.refractory_ms = '0;
      1: c.refractory_ms = '1;
      2: c.refractory_ms = 16'($urandom_range(0, 65535));
      default: c.refractory_ms = 16'($urandom_range(20, 400));
    endcase
    c.beats_per_average = 4'($urandom_range(0, 15));
    return c;
  endfunction

  task automatic random_run(input int count);
    logic [TIME_BITS-1:0]   stamp;
    logic [SAMPLE_BITS-1:0] value;
    stamp = $urandom;
    repeat (count) begin
      case ($urandom_range(9))
        0: stamp = $urandom;
        1: ; // hold the time stamp
        default: stamp = stamp + $urandom_range(1, 150);
      endcase
      case ($urandom_range(9))
        0, 1: value = SAMPLE_BITS'($urandom_range(2048, 4095));
        2: value = SAMPLE_BITS'($urandom);
        default: value = SAMPLE_BITS'($urandom_range(0, 2047));
      endcase
      send_sample(value, stamp);
    end
  endtask

  initial begin
    tracker = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: refractory edge, time wrap, first average
    send_sample(12'd0, 32'd0);
    send_sample(12'd4095, 32'd1000);
    send_sample(12'd4095, 32'd1300);
    send_sample(12'd4095, 32'd1301);
    send_sample(12'd2970, 32'hFFFF_FF00);
    send_sample(12'd100, 32'h0000_0100);
    send_sample(12'd0, 32'h0000_0500);
    drain();

    // all-zero registers: unit divisor and window, average on every beat
    load_settings('{16'd0, 8'd0, 8'd0, 5'd0, 16'd0, 4'd0});
    send_sample(12'd0, 32'h8000_0000);
    send_sample(12'd4095, 32'h8000_0001);
    send_sample(12'd7, 32'h8000_0001);
    send_sample(12'd16, 32'h8000_0003);
    send_sample(12'd17, 32'h8000_03E8);
    drain();

    // top registers: level pinned low, beats unreachable
    load_settings('{16'hFFFF, 8'hFF, 8'hFF, 5'd31, 16'hFFFF, 4'd15});
    send_sample(12'd4095, 32'd0);
    send_sample(12'd4095, 32'hFFFF_FFFF);
    send_sample(12'd0, 32'd5);
    drain();

    // collect beats, then lower the averaging count below them
    load_settings('{16'd3, 8'd16, 8'd240, 5'd14, 16'd1000, 4'd15});
    send_sample(12'd4095, 32'd10000);
    send_sample(12'd4095, 32'd11001);
    send_sample(12'd4095, 32'd12002);
    send_sample(12'd4095, 32'd13003);
    drain();
    load_settings('{16'd3, 8'd16, 8'd240, 5'd14, 16'd1000, 4'd2});
    send_sample(12'd4095, 32'd14004);
    send_sample(12'd4000, 32'd16000);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      steady = (phase == 2);
      load_settings(random_settings());
      random_run(80);
      drain();
    end
    steady = 1'b0;

    repeat (100) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: ecg_beat_rate_detector.f
rtl/ebrd_pkg.sv
rtl/ebrd_div.sv
rtl/ecg_beat_rate_detector.sv
bench/tb.sv
